### hdl/tmps_pkg.sv
// Shared types and constants for the trapezoid motion position step unit.
// No dependencies; every other file in hdl/ imports this package.
package tmps_pkg;

  localparam int POS_W         = 24;
  localparam int DIST_W        = 23;
  localparam int TIME_W        = 20;
  localparam int TSUM_W        = TIME_W + 1;
  localparam int POS_FRAC_BITS = 8;
  localparam int NUDGE         = ((1 << POS_FRAC_BITS) + 5) / 10;
  localparam int INC_W         = 25;
  localparam int Q_W           = 48;
  localparam int NUM_W         = 88;
  localparam int DV_W          = 41;
  localparam int ROOT_W        = Q_W / 2;
  localparam int SREM_W        = ROOT_W + 2;
  localparam int FRONT_STAGES  = 4;

  localparam logic [INC_W-1:0] INC_SAT = INC_W'(1) << (INC_W - 1);

  localparam logic [1:0] REG_TOTAL_DISTANCE = 2'd0;
  localparam logic [1:0] REG_RAMP_TIME      = 2'd1;
  localparam logic [1:0] REG_CRUISE_TIME    = 2'd2;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_UP,
    MODE_DOWN,
    MODE_CRUISE
  } mode_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [TIME_W-1:0] ramp;
    logic [TIME_W-1:0] cruise;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic [DIST_W-1:0]       s;
    mode_t                   mode;
  } ctx_t;

  typedef struct packed {
    ctx_t            ctx;
    logic            sat;
    logic [DV_W-1:0] rem;
    logic [Q_W-1:0]  w;
    logic [DV_W-1:0] dv;
  } div_in_t;

  typedef struct packed {
    ctx_t           ctx;
    logic           sat;
    logic [Q_W-1:0] q;
  } div_out_t;

  typedef struct packed {
    ctx_t              ctx;
    logic              sat;
    logic [INC_W-1:0]  cinc;
    logic [Q_W-1:0]    rad;
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

endpackage

### hdl/tmps_cfg_regs.sv
// APB-style configuration registers: total distance, ramp time, cruise time.
// Depends on tmps_pkg for the register indexes and the cfg_t bundle.
module tmps_cfg_regs import tmps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.distance <= '0;
      cfg_r.ramp     <= TIME_W'(65536);
      cfg_r.cruise   <= TIME_W'(65536);
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_TOTAL_DISTANCE: cfg_r.distance <= pwdata[DIST_W-1:0];
        REG_RAMP_TIME:      cfg_r.ramp     <= pwdata[TIME_W-1:0];
        REG_CRUISE_TIME:    cfg_r.cruise   <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TOTAL_DISTANCE: prdata = 32'(cfg_r.distance);
      REG_RAMP_TIME:      prdata = 32'(cfg_r.ramp);
      REG_CRUISE_TIME:    prdata = 32'(cfg_r.cruise);
      default:            prdata = '0;
    endcase
  end

endmodule

### hdl/tmps_front.sv
// Front end: segment decision, products and the dividend/divisor setup.
// Four register stages. Depends on tmps_pkg.
module tmps_front import tmps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  logic signed [POS_W-1:0] x_i,
  input  logic [TIME_W-1:0]       dt_i,
  input  cfg_t                    cfg,
  output logic                    vld_o,
  output div_in_t                 dat_o
);

  logic [FRONT_STAGES-1:0] v_r;

  // Stage 1: products.
  logic [TIME_W-1:0]      t1;
  logic [TSUM_W-1:0]      tsum;
  logic [TSUM_W:0]        tsum2;
  logic signed [POS_W:0]  xe, xp1, xn;
  logic signed [POS_W+1:0] dsx, dn;
  logic                   s1_lt_nxt, s1_xp1_pos_nxt, s1_dpos_nxt;
  logic [45:0]            s1_pa_nxt, s1_pb_nxt;
  logic [42:0]            s1_pst_nxt, s1_dts_nxt;
  logic [39:0]            s1_dd_nxt;
  logic [46:0]            s1_sdu_nxt, s1_sdd_nxt;
  logic [DV_W-1:0]        s1_dv_nxt;

  logic signed [POS_W-1:0] s1_x_r;
  logic [DIST_W-1:0]       s1_s_r;
  logic [TSUM_W-1:0]       s1_tsum_r;
  logic                    s1_lt_r, s1_xp1_pos_r, s1_dpos_r;
  logic [45:0]             s1_pa_r, s1_pb_r;
  logic [42:0]             s1_pst_r, s1_dts_r;
  logic [39:0]             s1_dd_r;
  logic [46:0]             s1_sdu_r, s1_sdd_r;
  logic [DV_W-1:0]         s1_dv_r;

  always_comb begin
    t1    = (cfg.ramp == '0) ? TIME_W'(1) : cfg.ramp;
    tsum  = TSUM_W'(t1) + TSUM_W'(cfg.cruise);
    tsum2 = {tsum, 1'b0};
    xe    = {x_i[POS_W-1], x_i};
    xp1   = xe + 25'sd1;
    xn    = xe + $signed(25'(NUDGE));
    dsx   = $signed({3'b000, cfg.distance}) - $signed({x_i[POS_W-1], x_i[POS_W-1], x_i});
    dn    = dsx + 26'sd1;
    s1_lt_nxt      = xe < $signed({2'b00, cfg.distance});
    s1_xp1_pos_nxt = !xp1[POS_W] && (xp1 != '0);
    s1_dpos_nxt    = !xn[POS_W] && (xn != '0);
    // Ramp-up test: x < floor(S*T1 / 2Tsum) is (x+1)*2Tsum <= S*T1 for x+1 > 0.
    s1_pa_nxt  = 46'(xp1[POS_W-1:0]) * 46'(tsum2);
    // Ramp-down test: S-x < floor(S*T1 / 2Tsum) is (S-x+1)*2Tsum <= S*T1.
    s1_pb_nxt  = 46'(dn[POS_W-1:0]) * 46'(tsum2);
    s1_pst_nxt = 43'(cfg.distance) * 43'(t1);
    s1_dd_nxt  = 40'(dt_i) * 40'(dt_i);
    s1_sdu_nxt = 47'(cfg.distance) * 47'(xn[POS_W-1:0]);
    s1_sdd_nxt = 47'(cfg.distance) * 47'(dsx[POS_W-1:0]);
    s1_dts_nxt = 43'(dt_i) * 43'(cfg.distance);
    s1_dv_nxt  = DV_W'(t1) * DV_W'(tsum);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r       <= x_i;
      s1_s_r       <= cfg.distance;
      s1_tsum_r    <= tsum;
      s1_lt_r      <= s1_lt_nxt;
      s1_xp1_pos_r <= s1_xp1_pos_nxt;
      s1_dpos_r    <= s1_dpos_nxt;
      s1_pa_r      <= s1_pa_nxt;
      s1_pb_r      <= s1_pb_nxt;
      s1_pst_r     <= s1_pst_nxt;
      s1_dd_r      <= s1_dd_nxt;
      s1_sdu_r     <= s1_sdu_nxt;
      s1_sdd_r     <= s1_sdd_nxt;
      s1_dts_r     <= s1_dts_nxt;
      s1_dv_r      <= s1_dv_nxt;
    end
  end

  // Stage 2: segment select and partial products of dt^2 * 2*S*D.
  logic        up, down;
  mode_t       s2_mode_nxt;
  logic [46:0] sd;
  logic [47:0] sd2;
  logic [43:0] pp0_nxt, pp1_nxt, pp2_nxt, pp3_nxt;

  ctx_t              s2_ctx_r;
  logic [43:0]       s2_pp0_r, s2_pp1_r, s2_pp2_r, s2_pp3_r;
  logic [42:0]       s2_dts_r;
  logic [DV_W-1:0]   s2_dv_r;
  logic [TSUM_W-1:0] s2_tsum_r;

  always_comb begin
    up   = s1_xp1_pos_r ? (s1_pa_r <= 46'(s1_pst_r)) : 1'b1;
    down = s1_pb_r <= 46'(s1_pst_r);
    if (!s1_lt_r) begin
      s2_mode_nxt = MODE_PASS;
    end else if (up) begin
      s2_mode_nxt = MODE_UP;
    end else if (down) begin
      s2_mode_nxt = MODE_DOWN;
    end else begin
      s2_mode_nxt = MODE_CRUISE;
    end
    if (s2_mode_nxt == MODE_UP) begin
      sd = s1_dpos_r ? s1_sdu_r : '0;
    end else begin
      sd = s1_sdd_r;
    end
    sd2     = {sd, 1'b0};
    pp0_nxt = 44'(s1_dd_r[19:0])  * 44'(sd2[23:0]);
    pp1_nxt = 44'(s1_dd_r[19:0])  * 44'(sd2[47:24]);
    pp2_nxt = 44'(s1_dd_r[39:20]) * 44'(sd2[23:0]);
    pp3_nxt = 44'(s1_dd_r[39:20]) * 44'(sd2[47:24]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctx_r.x    <= s1_x_r;
      s2_ctx_r.s    <= s1_s_r;
      s2_ctx_r.mode <= s2_mode_nxt;
      s2_pp0_r      <= pp0_nxt;
      s2_pp1_r      <= pp1_nxt;
      s2_pp2_r      <= pp2_nxt;
      s2_pp3_r      <= pp3_nxt;
      s2_dts_r      <= s1_dts_r;
      s2_dv_r       <= s1_dv_r;
      s2_tsum_r     <= s1_tsum_r;
    end
  end

  // Stage 3: sum the partial products and pick dividend and divisor.
  logic [NUM_W-1:0] nr;
  logic             ramp_seg;
  ctx_t             s3_ctx_r;
  logic [NUM_W-1:0] s3_num_r;
  logic [DV_W-1:0]  s3_dv_r;

  always_comb begin
    nr = {44'b0, s2_pp0_r} + {20'b0, s2_pp1_r, 24'b0}
       + {24'b0, s2_pp2_r, 20'b0} + {s2_pp3_r, 44'b0};
    ramp_seg = (s2_ctx_r.mode == MODE_UP) || (s2_ctx_r.mode == MODE_DOWN);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ctx_r <= s2_ctx_r;
      s3_num_r <= ramp_seg ? nr : NUM_W'(s2_dts_r);
      s3_dv_r  <= ramp_seg ? s2_dv_r : DV_W'(s2_tsum_r);
    end
  end

  // Stage 4: saturation check; a quotient of 2^48 or more is flagged.
  div_in_t s4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r.ctx <= s3_ctx_r;
      s4_r.sat <= {1'b0, s3_num_r[NUM_W-1:Q_W]} >= s3_dv_r;
      s4_r.rem <= {1'b0, s3_num_r[NUM_W-1:Q_W]};
      s4_r.w   <= s3_num_r[Q_W-1:0];
      s4_r.dv  <= s3_dv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[FRONT_STAGES-2:0], vld_i};
    end
  end

  assign vld_o = v_r[FRONT_STAGES-1];
  assign dat_o = s4_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("front valid bits moved during a stall");

endmodule

### hdl/tmps_div.sv
// Restoring divider, one quotient bit per pipeline stage, 48 stages.
// Depends on tmps_pkg for div_in_t and div_out_t.
module tmps_div import tmps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     vld_i,
  input  div_in_t  dat_i,
  output logic     vld_o,
  output div_out_t dat_o
);

  logic [Q_W-1:0] v_r;
  div_in_t        st_r   [Q_W];
  div_in_t        src    [Q_W];
  div_in_t        st_nxt [Q_W];
  logic [DV_W:0]  sh     [Q_W];
  logic [DV_W:0]  diff   [Q_W];
  logic           ge     [Q_W];

  always_comb begin
    src[0] = dat_i;
    for (int k = 1; k < Q_W; k++) begin
      src[k] = st_r[k-1];
    end
    for (int k = 0; k < Q_W; k++) begin
      // Bring down the next dividend bit; the quotient bit enters at the bottom.
      sh[k]         = {src[k].rem, src[k].w[Q_W-1]};
      diff[k]       = sh[k] - {1'b0, src[k].dv};
      ge[k]         = sh[k] >= {1'b0, src[k].dv};
      st_nxt[k]     = src[k];
      st_nxt[k].rem = ge[k] ? diff[k][DV_W-1:0] : sh[k][DV_W-1:0];
      st_nxt[k].w   = {src[k].w[Q_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < Q_W; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Q_W-2:0], vld_i};
    end
  end

  assign vld_o     = v_r[Q_W-1];
  assign dat_o.ctx = st_r[Q_W-1].ctx;
  assign dat_o.sat = st_r[Q_W-1].sat;
  assign dat_o.q   = st_r[Q_W-1].w;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[Q_W-1] && !st_r[Q_W-1].sat) |-> (st_r[Q_W-1].rem < st_r[Q_W-1].dv))
    else $error("divider remainder not below divisor");

endmodule

### hdl/tmps_sqrt.sv
// Integer square root, one root bit per stage, then add, clamp and output word.
// Depends on tmps_pkg for div_out_t and sq_t.
module tmps_sqrt import tmps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  div_out_t          dat_i,
  output logic              vld_o,
  output logic [DIST_W-1:0] pos_o
);

  logic [ROOT_W-1:0] v_r;
  sq_t               st_r   [ROOT_W];
  sq_t               src    [ROOT_W];
  sq_t               st_nxt [ROOT_W];
  logic [SREM_W+1:0] sh     [ROOT_W];
  logic [SREM_W+1:0] trial  [ROOT_W];
  logic              ge     [ROOT_W];

  always_comb begin
    src[0].ctx  = dat_i.ctx;
    src[0].sat  = dat_i.sat;
    // Cruise increment; anything of 2^24 or more reaches the clamp anyway.
    src[0].cinc = (dat_i.sat || (dat_i.q[Q_W-1:ROOT_W] != '0)) ? INC_SAT
                                                              : {1'b0, dat_i.q[ROOT_W-1:0]};
    src[0].rad  = dat_i.q;
    src[0].rem  = '0;
    src[0].root = '0;
    for (int k = 1; k < ROOT_W; k++) begin
      src[k] = st_r[k-1];
    end
    for (int k = 0; k < ROOT_W; k++) begin
      sh[k]          = {src[k].rem, src[k].rad[Q_W-1:Q_W-2]};
      trial[k]       = {2'b00, src[k].root, 2'b01};
      ge[k]          = sh[k] >= trial[k];
      st_nxt[k]      = src[k];
      st_nxt[k].rem  = ge[k] ? SREM_W'(sh[k] - trial[k]) : sh[k][SREM_W-1:0];
      st_nxt[k].root = {src[k].root[ROOT_W-2:0], ge[k]};
      st_nxt[k].rad  = {src[k].rad[Q_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // Final add and clamp to 0..S.
  sq_t                     last;
  logic [INC_W-1:0]        inc;
  logic signed [POS_W+2:0] sum;
  logic [DIST_W-1:0]       pos_nxt;
  logic [DIST_W-1:0]       pos_r;
  logic                    out_v_r;

  always_comb begin
    last = st_r[ROOT_W-1];
    case (last.ctx.mode) inside
      MODE_PASS:             inc = '0;
      MODE_UP, MODE_DOWN:    inc = last.sat ? INC_SAT : {1'b0, last.root};
      default:               inc = last.cinc;
    endcase
    sum = $signed({{3{last.ctx.x[POS_W-1]}}, last.ctx.x}) + $signed({2'b00, inc});
    if (sum[POS_W+2]) begin
      pos_nxt = '0;
    end else if (sum > $signed({4'b0000, last.ctx.s})) begin
      pos_nxt = last.ctx.s;
    end else begin
      pos_nxt = sum[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v_r     <= {v_r[ROOT_W-2:0], vld_i};
      out_v_r <= v_r[ROOT_W-1];
    end
  end

  assign vld_o = out_v_r;
  assign pos_o = pos_r;

  // A floor square root leaves a remainder of at most twice the root.
  a_root_is_floor: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ROOT_W-1] |-> (st_r[ROOT_W-1].rem <= {1'b0, st_r[ROOT_W-1].root, 1'b0}))
    else $error("square root remainder out of range");

endmodule

### hdl/trapezoid_motion_position_step_unit.sv
// Trapezoid motion position step unit: the path from input word to output word is
// 4 front stages, 48 divider stages, 24 root stages and an output register.
// Throughput one word per cycle; the depth is set by the divider and root, each
// resolving one bit per stage. A word not taken at the output holds the whole pipe.
// Synchronous active-low reset clears the valid bits and loads register defaults.
module trapezoid_motion_position_step_unit import tmps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] in_current_position,
  input  logic [TIME_W-1:0]       in_time_step,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [DIST_W-1:0]       out_next_position,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t     cfg;
  logic     en;
  logic     front_vld, div_vld;
  div_in_t  front_dat;
  div_out_t div_dat;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  tmps_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tmps_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_valid),
    .x_i   (in_current_position),
    .dt_i  (in_time_step),
    .cfg   (cfg),
    .vld_o (front_vld),
    .dat_o (front_dat)
  );

  tmps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (front_vld),
    .dat_i (front_dat),
    .vld_o (div_vld),
    .dat_o (div_dat)
  );

  tmps_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (div_vld),
    .dat_i (div_dat),
    .vld_o (out_valid),
    .pos_o (out_next_position)
  );

endmodule
